@@ hw/rtl/pwmc_pkg.sv @@
// Shared constants, configuration and point types for the PI duty controller.
`timescale 1ns / 1ps

package pwmc_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W   = 10;
    localparam int GAIN_W     = 16;
    localparam int INTEG_W    = 24;
    localparam int PERIOD_W   = 16;
    localparam int LEVEL_W    = 10;
    localparam int WLEN_W     = 11;
    localparam int DECIM_W    = 8;
    localparam int PHASE_W    = 10;
    localparam int ERR_W      = 11;
    localparam int INDEX_W    = 8;
    localparam int DUTY_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    // Datapath widths of the serial arithmetic.
    localparam int ACC_W  = 42;
    localparam int EP_W   = 27;
    localparam int IP_W   = 40;
    localparam int PCT_W  = 15;
    localparam int PROD_W = PCT_W + PERIOD_W;
    localparam int FRAC_W = 8;
    localparam int QUOT_W = PROD_W - FRAC_W;
    localparam int REM_W  = 7;

    localparam int ADC_BITS       = 10;
    localparam int CAPTURE_POINTS = 200;

    localparam logic [SAMPLE_W-1:0] ADC_MASK    = SAMPLE_W'((1 << ADC_BITS) - 1);
    localparam logic [INDEX_W-1:0]  CAPTURE_END = INDEX_W'(CAPTURE_POINTS);
    localparam logic [WLEN_W-1:0]   WLEN_LIMIT  = WLEN_W'(1024);
    localparam logic [ACC_W-1:0]    HALF_PCT    = ACC_W'(12800);
    localparam logic [ACC_W-1:0]    FULL_PCT    = ACC_W'(25600);
    localparam logic [REM_W:0]      DIVISOR     = (REM_W + 1)'(100);

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W - 1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W - 1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP           = 8'd0,
        REG_KI           = 8'd1,
        REG_INTEGRAL_MAX = 8'd2,
        REG_PWM_PERIOD   = 8'd3,
        REG_REF_HIGH     = 8'd4,
        REG_REF_LOW      = 8'd5,
        REG_WAVE_LENGTH  = 8'd6,
        REG_DECIMATION   = 8'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [INTEG_W-1:0] integral_max;
        logic [PERIOD_W-1:0]       pwm_period;
        logic [LEVEL_W-1:0]        ref_high;
        logic [LEVEL_W-1:0]        ref_low;
        logic [WLEN_W-1:0]         wave_length;
        logic [DECIM_W-1:0]        decimation;
    } pwmc_cfg_t;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
        logic [LEVEL_W-1:0]  reference;
        logic                done;
    } pwmc_point_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_FIN   = 5'b10000
    } top_state_t;

    typedef enum logic [2:0] {
        SC_IDLE = 3'b001,
        SC_MUL  = 3'b010,
        SC_DIV  = 3'b100
    } scale_state_t;

endpackage

@@ hw/rtl/pi_pwm_controller_with_capture.sv @@
// Top level of the PI duty controller with decimated (sample, reference) capture.
// Items are taken one at a time: a new item is accepted only once the previous result has been
// loaded into the output register, after the serial arithmetic: a 16-step gain
// multiply-accumulate, a 16-step multiply by the period and a 23-step divide by 100.
// A finished result waits in the output register while the next item is accepted.
// Reset (aresetn low, synchronous) restores the register defaults and clears the integrator, phase and capture state.
`timescale 1ns / 1ps

module pi_pwm_controller_with_capture (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input items.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pwmc_pkg::S_TDATA_W-1:0]     s_tdata,   // [9:0] adc_sample, [15:10] zero
    input  logic [0:0]                         s_tuser,   // [0] start_capture
    // Result items.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pwmc_pkg::M_TDATA_W-1:0]     m_tdata,   // [15:0] duty_compare,
                                                          // [25:16] point_sample,
                                                          // [35:26] point_reference,
                                                          // [39:36] zero
    output logic [0:0]                         m_tuser,   // [0] point_valid
    output logic                               m_tlast,   // capture_done
    // Register writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pwmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwmc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    pwmc_pkg::pwmc_cfg_t                   cfg_reg;
    pwmc_pkg::top_state_t                  state_reg, state_next;
    logic                                  s_accept, cfg_accept, out_free, out_load;
    logic                                  mac_start, mac_done, scale_start, scale_done;
    logic signed [pwmc_pkg::ERR_W-1:0]     err;
    logic signed [pwmc_pkg::INTEG_W-1:0]   integ;
    logic [pwmc_pkg::PCT_W-1:0]            pct;
    logic [pwmc_pkg::DUTY_W-1:0]           duty;
    pwmc_pkg::pwmc_point_t                 point;
    logic                                  m_tvalid_reg;
    logic [pwmc_pkg::DUTY_W-1:0]           duty_reg;
    pwmc_pkg::pwmc_point_t                 point_reg;

    assign s_tready   = aresetn && (state_reg == pwmc_pkg::ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = aresetn;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = (state_reg == pwmc_pkg::ST_FIN) && out_free;
    assign mac_start  = (state_reg == pwmc_pkg::ST_LOAD);
    assign scale_start = (state_reg == pwmc_pkg::ST_MAC) && mac_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp           <= '0;
            cfg_reg.ki           <= '0;
            cfg_reg.integral_max <= '0;
            cfg_reg.pwm_period   <= pwmc_pkg::PERIOD_W'(2399);
            cfg_reg.ref_high     <= pwmc_pkg::LEVEL_W'(700);
            cfg_reg.ref_low      <= pwmc_pkg::LEVEL_W'(300);
            cfg_reg.wave_length  <= pwmc_pkg::WLEN_W'(1000);
            cfg_reg.decimation   <= pwmc_pkg::DECIM_W'(10);
        end else if (cfg_accept) begin
            unique case (cfg_index)
                pwmc_pkg::REG_KP:           cfg_reg.kp <= cfg_wdata[pwmc_pkg::GAIN_W-1:0];
                pwmc_pkg::REG_KI:           cfg_reg.ki <= cfg_wdata[pwmc_pkg::GAIN_W-1:0];
                pwmc_pkg::REG_INTEGRAL_MAX: cfg_reg.integral_max <= cfg_wdata;
                pwmc_pkg::REG_PWM_PERIOD:
                    cfg_reg.pwm_period <= cfg_wdata[pwmc_pkg::PERIOD_W-1:0];
                pwmc_pkg::REG_REF_HIGH:     cfg_reg.ref_high <= cfg_wdata[pwmc_pkg::LEVEL_W-1:0];
                pwmc_pkg::REG_REF_LOW:      cfg_reg.ref_low <= cfg_wdata[pwmc_pkg::LEVEL_W-1:0];
                pwmc_pkg::REG_WAVE_LENGTH:
                    cfg_reg.wave_length <= cfg_wdata[pwmc_pkg::WLEN_W-1:0];
                pwmc_pkg::REG_DECIMATION:
                    cfg_reg.decimation <= cfg_wdata[pwmc_pkg::DECIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pwmc_pkg::ST_IDLE:  if (s_accept) state_next = pwmc_pkg::ST_LOAD;
            pwmc_pkg::ST_LOAD:  state_next = pwmc_pkg::ST_MAC;
            pwmc_pkg::ST_MAC:   if (mac_done) state_next = pwmc_pkg::ST_SCALE;
            pwmc_pkg::ST_SCALE: if (scale_done) state_next = pwmc_pkg::ST_FIN;
            pwmc_pkg::ST_FIN:   if (out_free) state_next = pwmc_pkg::ST_IDLE;
            default:            state_next = pwmc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pwmc_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            duty_reg  <= duty;
            point_reg <= point;
        end
    end

    pwmc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .sample  (s_tdata[pwmc_pkg::SAMPLE_W-1:0]),
        .start   (s_tuser[0]),
        .cfg     (cfg_reg),
        .err     (err),
        .integ   (integ),
        .point   (point)
    );

    pwmc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .err     (err),
        .integ   (integ),
        .kp      (cfg_reg.kp),
        .ki      (cfg_reg.ki),
        .done    (mac_done),
        .pct     (pct)
    );

    pwmc_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scale_start),
        .pct     (pct),
        .period  (cfg_reg.pwm_period),
        .done    (scale_done),
        .duty    (duty)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(pwmc_pkg::M_TDATA_W - pwmc_pkg::DUTY_W - pwmc_pkg::SAMPLE_W
                         - pwmc_pkg::LEVEL_W){1'b0}},
                       point_reg.reference, point_reg.sample, duty_reg};
    assign m_tuser  = point_reg.valid;
    assign m_tlast  = point_reg.done;

endmodule

@@ hw/rtl/pwmc_front.sv @@
// Per-tick state update: reference, error, clamped integrator and capture sequencing.
`timescale 1ns / 1ps

module pwmc_front (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     accept,
    input  logic [pwmc_pkg::SAMPLE_W-1:0]            sample,
    input  logic                                     start,
    input  pwmc_pkg::pwmc_cfg_t                      cfg,
    output logic signed [pwmc_pkg::ERR_W-1:0]        err,
    output logic signed [pwmc_pkg::INTEG_W-1:0]      integ,
    output pwmc_pkg::pwmc_point_t                    point
);

    logic signed [pwmc_pkg::INTEG_W-1:0] integ_reg, integ_next;
    logic [pwmc_pkg::PHASE_W-1:0]        phase_reg, phase_next;
    logic [pwmc_pkg::DECIM_W-1:0]        dcount_reg, dcount_next;
    logic [pwmc_pkg::INDEX_W-1:0]        cindex_reg, cindex_next;
    logic                                active_reg, active_next;
    logic signed [pwmc_pkg::ERR_W-1:0]   err_reg, err_next;
    pwmc_pkg::pwmc_point_t               point_reg, point_next;

    logic [pwmc_pkg::SAMPLE_W-1:0]       sample_m;
    logic [pwmc_pkg::WLEN_W-1:0]         wl;
    logic [pwmc_pkg::WLEN_W-1:0]         nxt_phase;
    logic [pwmc_pkg::LEVEL_W-1:0]        ref_val;
    logic signed [pwmc_pkg::INTEG_W-1:0] base;
    logic signed [pwmc_pkg::INTEG_W:0]   sum_w;
    logic signed [pwmc_pkg::INTEG_W-1:0] sat;
    logic [pwmc_pkg::DECIM_W-1:0]        dc_inc;
    logic [pwmc_pkg::INDEX_W-1:0]        ci_base, ci_inc;
    logic                                act, pt_valid, pt_done;

    always_comb begin
        sample_m = sample & pwmc_pkg::ADC_MASK;
        wl = (cfg.wave_length > pwmc_pkg::WLEN_LIMIT) ? pwmc_pkg::WLEN_LIMIT : cfg.wave_length;
        ref_val = ({1'b0, phase_reg} < (wl >> 1)) ? cfg.ref_high : cfg.ref_low;
        err_next = $signed({1'b0, sample_m}) - $signed({1'b0, ref_val});

        // The start pulse clears the integrator before this tick's error goes in.
        base  = start ? '0 : integ_reg;
        sum_w = {base[pwmc_pkg::INTEG_W-1], base}
              + {{(pwmc_pkg::INTEG_W + 1 - pwmc_pkg::ERR_W){err_next[pwmc_pkg::ERR_W-1]}},
                 err_next};
        if (sum_w[pwmc_pkg::INTEG_W] != sum_w[pwmc_pkg::INTEG_W-1]) begin
            sat = sum_w[pwmc_pkg::INTEG_W] ? pwmc_pkg::INTEG_MIN : pwmc_pkg::INTEG_MAX;
        end else begin
            sat = sum_w[pwmc_pkg::INTEG_W-1:0];
        end
        integ_next = (sat > cfg.integral_max) ? cfg.integral_max : sat;

        act      = start | active_reg;
        dc_inc   = (start ? '0 : dcount_reg) + 1'b1;
        ci_base  = start ? '0 : cindex_reg;
        pt_valid = act && (dc_inc == cfg.decimation);
        ci_inc   = pt_valid ? ci_base + 1'b1 : ci_base;
        pt_done  = act && (ci_inc == pwmc_pkg::CAPTURE_END);

        dcount_next = act ? (pt_valid ? '0 : dc_inc) : dcount_reg;
        cindex_next = act ? (pt_done ? '0 : ci_inc) : cindex_reg;
        active_next = act && !pt_done;

        nxt_phase  = {1'b0, phase_reg} + 1'b1;
        phase_next = (nxt_phase >= wl) ? '0 : nxt_phase[pwmc_pkg::PHASE_W-1:0];

        point_next.valid     = pt_valid;
        point_next.sample    = pt_valid ? sample_m : '0;
        point_next.reference = pt_valid ? ref_val : '0;
        point_next.done      = pt_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg  <= '0;
            phase_reg  <= '0;
            dcount_reg <= '0;
            cindex_reg <= '0;
            active_reg <= 1'b0;
        end else if (accept) begin
            integ_reg  <= integ_next;
            phase_reg  <= phase_next;
            dcount_reg <= dcount_next;
            cindex_reg <= cindex_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            err_reg   <= err_next;
            point_reg <= point_next;
        end
    end

    assign err   = err_reg;
    assign integ = integ_reg;
    assign point = point_reg;

endmodule

@@ hw/rtl/pwmc_mac.sv @@
// Bit-serial signed multiply-accumulate of kp*err + ki*integ + 50 percent, clamped to 0..100.
`timescale 1ns / 1ps

module pwmc_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [pwmc_pkg::ERR_W-1:0]    err,
    input  logic signed [pwmc_pkg::INTEG_W-1:0]  integ,
    input  logic signed [pwmc_pkg::GAIN_W-1:0]   kp,
    input  logic signed [pwmc_pkg::GAIN_W-1:0]   ki,
    output logic                                 done,
    output logic [pwmc_pkg::PCT_W-1:0]           pct
);

    localparam int CNT_W = $clog2(pwmc_pkg::GAIN_W);

    logic                                busy_reg, done_reg;
    logic [CNT_W-1:0]                    cnt_reg;
    logic [pwmc_pkg::GAIN_W-1:0]         kp_sh_reg, ki_sh_reg;
    logic signed [pwmc_pkg::EP_W-1:0]    err_sh_reg;
    logic signed [pwmc_pkg::IP_W-1:0]    int_sh_reg;
    logic signed [pwmc_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic signed [pwmc_pkg::ACC_W-1:0]   t_p, t_i;
    logic                                last;

    always_comb begin
        last = (cnt_reg == CNT_W'(pwmc_pkg::GAIN_W - 1));
        t_p  = kp_sh_reg[0]
             ? {{(pwmc_pkg::ACC_W - pwmc_pkg::EP_W){err_sh_reg[pwmc_pkg::EP_W-1]}}, err_sh_reg}
             : '0;
        t_i  = ki_sh_reg[0]
             ? {{(pwmc_pkg::ACC_W - pwmc_pkg::IP_W){int_sh_reg[pwmc_pkg::IP_W-1]}}, int_sh_reg}
             : '0;
        // The gain's top bit carries negative weight in two's complement.
        acc_next = last ? acc_reg - t_p - t_i : acc_reg + t_p + t_i;

        if (acc_reg[pwmc_pkg::ACC_W-1]) begin
            pct = '0;
        end else if ($unsigned(acc_reg) > pwmc_pkg::FULL_PCT) begin
            pct = pwmc_pkg::FULL_PCT[pwmc_pkg::PCT_W-1:0];
        end else begin
            pct = acc_reg[pwmc_pkg::PCT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            kp_sh_reg  <= kp;
            ki_sh_reg  <= ki;
            err_sh_reg <= {{(pwmc_pkg::EP_W - pwmc_pkg::ERR_W){err[pwmc_pkg::ERR_W-1]}}, err};
            int_sh_reg <= {{(pwmc_pkg::IP_W - pwmc_pkg::INTEG_W){integ[pwmc_pkg::INTEG_W-1]}},
                           integ};
            acc_reg    <= pwmc_pkg::HALF_PCT;
        end else if (busy_reg) begin
            kp_sh_reg  <= kp_sh_reg >> 1;
            ki_sh_reg  <= ki_sh_reg >> 1;
            err_sh_reg <= err_sh_reg <<< 1;
            int_sh_reg <= int_sh_reg <<< 1;
            acc_reg    <= acc_next;
        end
    end

    assign done = done_reg;

endmodule

@@ hw/rtl/pwmc_scale.sv @@
// Serial scaling of the duty percentage: multiply by the period, then divide by 25600.
`timescale 1ns / 1ps

module pwmc_scale (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pwmc_pkg::PCT_W-1:0]     pct,
    input  logic [pwmc_pkg::PERIOD_W-1:0]  period,
    output logic                           done,
    output logic [pwmc_pkg::DUTY_W-1:0]    duty
);

    localparam int CNT_W = $clog2(pwmc_pkg::QUOT_W);

    pwmc_pkg::scale_state_t          state_reg;
    logic                            done_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [pwmc_pkg::PERIOD_W-1:0]   mul_sh_reg;
    logic [pwmc_pkg::PROD_W-1:0]     mcand_reg;
    logic [pwmc_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic [pwmc_pkg::QUOT_W-1:0]     quot_reg;
    logic [pwmc_pkg::REM_W-1:0]      rem_reg;
    logic [pwmc_pkg::REM_W:0]        rem_t, rem_sub;
    logic                            ge;
    logic                            mul_last, div_last;

    always_comb begin
        prod_next = prod_reg + (mul_sh_reg[0] ? mcand_reg : '0);
        mul_last  = (cnt_reg == CNT_W'(pwmc_pkg::PERIOD_W - 1));
        div_last  = (cnt_reg == CNT_W'(pwmc_pkg::QUOT_W - 1));
        // Restoring division by 100, one quotient bit per cycle.
        rem_t   = {rem_reg, quot_reg[pwmc_pkg::QUOT_W-1]};
        ge      = (rem_t >= pwmc_pkg::DIVISOR);
        rem_sub = rem_t - pwmc_pkg::DIVISOR;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pwmc_pkg::SC_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                pwmc_pkg::SC_IDLE: begin
                    if (start) begin
                        state_reg <= pwmc_pkg::SC_MUL;
                        cnt_reg   <= '0;
                    end
                end
                pwmc_pkg::SC_MUL: begin
                    if (mul_last) begin
                        state_reg <= pwmc_pkg::SC_DIV;
                        cnt_reg   <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                pwmc_pkg::SC_DIV: begin
                    if (div_last) begin
                        state_reg <= pwmc_pkg::SC_IDLE;
                        done_reg  <= 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: begin
                    state_reg <= pwmc_pkg::SC_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            pwmc_pkg::SC_IDLE: begin
                if (start) begin
                    mul_sh_reg <= period;
                    mcand_reg  <= {{(pwmc_pkg::PROD_W - pwmc_pkg::PCT_W){1'b0}}, pct};
                    prod_reg   <= '0;
                end
            end
            pwmc_pkg::SC_MUL: begin
                mul_sh_reg <= mul_sh_reg >> 1;
                mcand_reg  <= mcand_reg << 1;
                prod_reg   <= prod_next;
                if (mul_last) begin
                    // Dropping the low byte divides by 256; the divide by 100 follows.
                    quot_reg <= prod_next[pwmc_pkg::PROD_W-1:pwmc_pkg::FRAC_W];
                    rem_reg  <= '0;
                end
            end
            pwmc_pkg::SC_DIV: begin
                rem_reg  <= ge ? rem_sub[pwmc_pkg::REM_W-1:0] : rem_t[pwmc_pkg::REM_W-1:0];
                quot_reg <= {quot_reg[pwmc_pkg::QUOT_W-2:0], ge};
            end
            default: begin
            end
        endcase
    end

    assign done = done_reg;
    assign duty = quot_reg[pwmc_pkg::DUTY_W-1:0];

endmodule

@@ hw/rtl/pwmc_checker.sv @@
// Port-level checks for the PI duty controller, bound to its top level.
`timescale 1ns / 1ps

module pwmc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pwmc_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [0:0]                      m_tuser,
    input logic                            m_tlast
);

    // One item at a time: the input side closes right after an item is taken.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while an item is in progress");

    // A result never shows up in the cycle right after its item is accepted.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early after an accepted item");

    // Without a captured point the sample and reference fields are zero.
    a_point_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[35:16] == 20'd0))
        else $error("point fields nonzero on an item without a point");

    // The end of a capture run always coincides with its last point.
    a_done_has_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("capture done flagged without a captured point");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind pi_pwm_controller_with_capture pwmc_checker u_pwmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
